// File: hdl/gbnsw_pkg.sv
package gbnsw_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int PTR_W       = SLOT_W + 1;

	// Most frames outstanding, and the per-item frame counter
	localparam int WINDOW_MAX = 4;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

	// Field widths
	localparam int NUM_W   = 16;
	localparam int LOW_W   = 64;
	localparam int HIGH_W  = 40;
	localparam int ENTRY_W = NUM_W + LOW_W + HIGH_W;
	localparam int CFG_W   = 3;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_NEWLINE = 1'b1;
	localparam logic [CFG_W-1:0] WINDOW_RESET  = 3'd4;
	localparam logic [CFG_W-1:0] NEWLINE_RESET = 3'd3;

	// Frame constants
	localparam logic [NUM_W-1:0] FIRST_NUMBER = 16'd1;
	localparam logic [7:0]       NEWLINE_BYTE = 8'h0A;
	localparam logic [CFG_W-1:0] NL_SAT       = 3'd7;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_ACK     = 2'd1,
		OP_TICK    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

endpackage

// File: hdl/gbnsw_ram.sv
module gbnsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/go_back_n_sender_window.sv
// Go-back-N sender window.
// A request is taken in S_IDLE; an ack or tick with frames unacked first reads the oldest entry in S_HEAD_RD.
// Each frame then passes S_SEND (one store read) and S_SEND_RD (one output load, held by an output stall).
// New requests are stalled until the sequencer is back in S_IDLE; 0..4 frames are sent per request.
// Reset (arst_n low): window_limit 4, newline_run 3, next number 1, store empty, not halted.
// Store contents are not cleared; only entries already written are ever read.
module go_back_n_sender_window (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       op,
	input  logic [gbnsw_pkg::LOW_W-1:0]      payload_low,
	input  logic [gbnsw_pkg::HIGH_W-1:0]     payload_high,
	input  logic [gbnsw_pkg::NUM_W-1:0]      ack_number,
	input  logic                             ack_text_ok,
	// frame channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gbnsw_pkg::NUM_W-1:0]      frame_number,
	output logic [gbnsw_pkg::LOW_W-1:0]      frame_low,
	output logic [gbnsw_pkg::HIGH_W-1:0]     frame_high,
	output logic                             final_send,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gbnsw_pkg::ADDR_W-1:0]     paddr,
	input  logic [gbnsw_pkg::DATA_W-1:0]     pwdata,
	output logic [gbnsw_pkg::DATA_W-1:0]     prdata,
	output logic                             pready
);

	localparam int PW = gbnsw_pkg::PTR_W;
	localparam int CW = gbnsw_pkg::CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD_RD,
		S_SEND,
		S_SEND_RD
	} state_t;

	state_t                           state_q;
	gbnsw_pkg::op_t                   op_q;
	logic [gbnsw_pkg::NUM_W-1:0]      ack_number_q;
	logic                             ack_ok_q;
	logic [gbnsw_pkg::NUM_W-1:0]      next_number_q;
	logic [PW-1:0]                    head_q;
	logic [PW-1:0]                    send_q;
	logic [PW-1:0]                    fill_q;
	logic [gbnsw_pkg::NUM_W-1:0]      seen_oldest_q;
	logic                             seen_valid_q;
	logic [gbnsw_pkg::CFG_W-1:0]      nl_count_q;
	logic                             halted_q;
	logic [CW-1:0]                    count_q;
	logic [gbnsw_pkg::CFG_W-1:0]      window_q;
	logic [gbnsw_pkg::CFG_W-1:0]      newline_q;
	logic                             out_valid_q;
	logic [gbnsw_pkg::NUM_W-1:0]      frame_number_q;
	logic [gbnsw_pkg::LOW_W-1:0]      frame_low_q;
	logic [gbnsw_pkg::HIGH_W-1:0]     frame_high_q;
	logic                             final_q;

	logic                             in_acc;
	logic                             out_take;
	logic                             out_load;
	logic                             cfg_wr;
	gbnsw_pkg::op_t                   op_in;
	logic [PW-1:0]                    fill_dist;
	logic [PW-1:0]                    unacked_dist;
	logic                             not_full;
	logic [PW-1:0]                    limit;
	logic                             ram_we;
	logic                             ram_re;
	logic [gbnsw_pkg::SLOT_W-1:0]     ram_raddr;
	logic [gbnsw_pkg::ENTRY_W-1:0]    ram_rdata;
	logic [gbnsw_pkg::NUM_W-1:0]      rd_number;
	logic [gbnsw_pkg::LOW_W-1:0]      rd_low;
	logic [gbnsw_pkg::HIGH_W-1:0]     rd_high;
	logic [gbnsw_pkg::CFG_W-1:0]      nl_next;
	logic                             halt_next;
	logic [PW-1:0]                    send_next;
	logic [CW-1:0]                    count_next;
	logic                             can_send_now;
	logic                             more;
	logic                             out_free;

	// Window test: another frame may go out from pointer sp
	function automatic logic can_send(input logic [PW-1:0] sp, input logic [CW-1:0] cnt,
			input logic hlt, input logic [PW-1:0] hd, input logic [PW-1:0] fl,
			input logic [PW-1:0] lim);
		logic [PW-1:0] d;
		d = sp - hd;
		return !hlt && (sp != fl) && (d < lim) && (cnt < CW'(gbnsw_pkg::WINDOW_MAX));
	endfunction

	// Handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_SEND_RD) && out_free;
	assign op_in    = gbnsw_pkg::op_t'(op);
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	// Occupancy and effective window
	assign fill_dist    = fill_q - head_q;
	assign unacked_dist = send_q - head_q;
	assign not_full     = !fill_dist[PW-1];
	assign limit = (PW'(window_q) > PW'(gbnsw_pkg::WINDOW_MAX)) ?
		PW'(gbnsw_pkg::WINDOW_MAX) : PW'(window_q);

	// Frame store
	assign ram_we = in_acc && !halted_q && (op_in == gbnsw_pkg::OP_ENQUEUE) && not_full;
	assign can_send_now = can_send(send_q, count_q, halted_q, head_q, fill_q, limit);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q[gbnsw_pkg::SLOT_W-1:0];
		if (state_q == S_IDLE) begin
			ram_re = in_acc && !halted_q && (send_q != head_q) &&
				((op_in == gbnsw_pkg::OP_ACK) || (op_in == gbnsw_pkg::OP_TICK));
		end else if (state_q == S_SEND) begin
			ram_re    = can_send_now;
			ram_raddr = send_q[gbnsw_pkg::SLOT_W-1:0];
		end
	end

	gbnsw_ram #(
		.WIDTH(gbnsw_pkg::ENTRY_W),
		.DEPTH(gbnsw_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[gbnsw_pkg::SLOT_W-1:0]),
		.wdata({next_number_q, payload_low, payload_high}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_number = ram_rdata[gbnsw_pkg::ENTRY_W-1 -: gbnsw_pkg::NUM_W];
	assign rd_low    = ram_rdata[gbnsw_pkg::HIGH_W +: gbnsw_pkg::LOW_W];
	assign rd_high   = ram_rdata[gbnsw_pkg::HIGH_W-1:0];

	// Effect of the frame just read: newline run, halt, and whether another follows
	always_comb begin
		if (rd_low[7:0] == gbnsw_pkg::NEWLINE_BYTE) begin
			nl_next = (nl_count_q == gbnsw_pkg::NL_SAT) ? nl_count_q : nl_count_q + 1'b1;
		end else begin
			nl_next = '0;
		end
		halt_next  = (nl_next >= newline_q);
		send_next  = send_q + 1'b1;
		count_next = count_q + 1'b1;
		more = can_send(send_next, count_next, halt_next, head_q, fill_q, limit);
	end

	// Register readback
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			gbnsw_pkg::REG_WINDOW:  prdata = gbnsw_pkg::DATA_W'(window_q);
			gbnsw_pkg::REG_NEWLINE: prdata = gbnsw_pkg::DATA_W'(newline_q);
			default:                prdata = '0;
		endcase
	end

	// Sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= gbnsw_pkg::OP_NONE;
			ack_number_q   <= '0;
			ack_ok_q       <= 1'b0;
			next_number_q  <= gbnsw_pkg::FIRST_NUMBER;
			head_q         <= '0;
			send_q         <= '0;
			fill_q         <= '0;
			seen_oldest_q  <= '0;
			seen_valid_q   <= 1'b0;
			nl_count_q     <= '0;
			halted_q       <= 1'b0;
			count_q        <= '0;
			window_q       <= gbnsw_pkg::WINDOW_RESET;
			newline_q      <= gbnsw_pkg::NEWLINE_RESET;
			out_valid_q    <= 1'b0;
			frame_number_q <= '0;
			frame_low_q    <= '0;
			frame_high_q   <= '0;
			final_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == gbnsw_pkg::REG_WINDOW) begin
					window_q <= pwdata[gbnsw_pkg::CFG_W-1:0];
				end else begin
					newline_q <= pwdata[gbnsw_pkg::CFG_W-1:0];
				end
			end

			// Output valid: set on a load, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && !halted_q) begin
						op_q         <= op_in;
						ack_number_q <= ack_number;
						ack_ok_q     <= ack_text_ok;
						count_q      <= '0;
						if (ram_we) begin
							fill_q        <= fill_q + 1'b1;
							next_number_q <= next_number_q + 1'b1;
						end
						state_q <= ram_re ? S_HEAD_RD : S_SEND;
					end
				end
				S_HEAD_RD: begin
					// oldest unacked number is on the read port
					if (op_q == gbnsw_pkg::OP_ACK) begin
						if (ack_ok_q && (rd_number == ack_number_q)) begin
							head_q <= head_q + 1'b1;
						end
					end else if (seen_valid_q && (seen_oldest_q == rd_number)) begin
						send_q <= head_q;
					end else begin
						seen_oldest_q <= rd_number;
						seen_valid_q  <= 1'b1;
					end
					state_q <= S_SEND;
				end
				S_SEND: begin
					state_q <= can_send_now ? S_SEND_RD : S_IDLE;
				end
				S_SEND_RD: begin
					if (out_free) begin
						frame_number_q <= rd_number;
						frame_low_q    <= rd_low;
						frame_high_q   <= rd_high;
						final_q        <= !more;
						send_q         <= send_next;
						nl_count_q     <= nl_next;
						halted_q       <= halt_next;
						count_q        <= count_next;
						state_q        <= more ? S_SEND : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_number = frame_number_q;
	assign frame_low    = frame_low_q;
	assign frame_high   = frame_high_q;
	assign final_send   = final_q;

`ifndef SYNTH
	a_window_cap: assert property (@(posedge clk) disable iff (!arst_n)
		unacked_dist <= PW'(gbnsw_pkg::WINDOW_MAX))
		else $error("more frames outstanding than the window allows");

	a_store_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_dist <= PW'(gbnsw_pkg::STORE_DEPTH))
		else $error("frame store overfilled");

	a_send_order: assert property (@(posedge clk) disable iff (!arst_n)
		unacked_dist <= fill_dist)
		else $error("send pointer ran past the fill pointer");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_no_send_halted: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted_q) && halted_q |-> !$rose(out_valid_q))
		else $error("frame sent while halted");
`endif

endmodule
